// ===== rtl/tre_pkg.sv =====
// Shared types and constants for the trapezoid envelope generator.
package tre_pkg;

    // Width of the running time word
    localparam int TIME_BITS = 32;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_RISE = 2'd0;
    localparam logic [1:0] REG_HOLD = 2'd1;
    localparam logic [1:0] REG_FALL = 2'd2;
    localparam logic [1:0] REG_OFF  = 2'd3;

    // Per-word flags that ride along with the fraction divider
    typedef struct packed {
        logic is_full;
        logic is_zero;
        logic hold_start;
        logic period_zero;
    } tre_meta_t;

endpackage

// ===== rtl/tre_mod.sv =====
// Pipelined restoring modulo: time word reduced by the period, one bit per stage.
module tre_mod #(
    parameter int LEN_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [tre_pkg::TIME_BITS-1:0] in_time,
    input  logic [LEN_BITS+1:0]           period,
    output logic                          out_valid,
    output logic [LEN_BITS+1:0]           out_phase
);
    localparam int PW = LEN_BITS + 2;
    localparam int N  = tre_pkg::TIME_BITS;

    logic [PW-1:0] rem_reg [N];
    logic [N-1:0]  tim_reg [N];
    logic [N-1:0]  vld_reg;

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_stage
            logic [PW-1:0] prev_rem;
            logic [N-1:0]  prev_tim;
            logic          prev_vld;
            logic [PW:0]   trial;
            logic [PW:0]   diff;
            logic          ge;
            logic [PW-1:0] rem_next;

            if (i == 0) begin : g_first
                assign prev_rem = '0;
                assign prev_tim = in_time;
                assign prev_vld = in_valid;
            end else begin : g_rest
                assign prev_rem = rem_reg[i-1];
                assign prev_tim = tim_reg[i-1];
                assign prev_vld = vld_reg[i-1];
            end

            // shift in the next time bit, subtract when it fits
            assign trial    = {prev_rem, prev_tim[N-1]};
            assign ge       = trial >= {1'b0, period};
            assign diff     = trial - {1'b0, period};
            assign rem_next = ge ? diff[PW-1:0] : trial[PW-1:0];

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[i] <= 1'b0;
                end else if (adv) begin
                    vld_reg[i] <= prev_vld;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[i] <= rem_next;
                    tim_reg[i] <= {prev_tim[N-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[N-1];
    assign out_phase = rem_reg[N-1];

endmodule

// ===== rtl/tre_div.sv =====
// Pipelined restoring fraction divider: (num << FRAC_BITS) / den with num < den.
module tre_div #(
    parameter int LEN_BITS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  tre_pkg::tre_meta_t in_meta,
    input  logic [LEN_BITS-1:0] in_num,
    input  logic [LEN_BITS-1:0] in_den,
    output logic               out_valid,
    output tre_pkg::tre_meta_t out_meta,
    output logic [FRAC_BITS-1:0] out_quo
);
    logic [LEN_BITS-1:0]  rem_reg  [FRAC_BITS];
    logic [LEN_BITS-1:0]  den_reg  [FRAC_BITS];
    logic [FRAC_BITS-1:0] quo_reg  [FRAC_BITS];
    tre_pkg::tre_meta_t   meta_reg [FRAC_BITS];
    logic [FRAC_BITS-1:0] vld_reg;

    genvar i;
    generate
        for (i = 0; i < FRAC_BITS; i++) begin : g_stage
            logic [LEN_BITS-1:0]  prev_rem;
            logic [LEN_BITS-1:0]  prev_den;
            logic [FRAC_BITS-1:0] prev_quo;
            tre_pkg::tre_meta_t   prev_meta;
            logic                 prev_vld;
            logic [LEN_BITS:0]    trial;
            logic [LEN_BITS:0]    diff;
            logic                 ge;

            if (i == 0) begin : g_first
                assign prev_rem  = in_num;
                assign prev_den  = in_den;
                assign prev_quo  = '0;
                assign prev_meta = in_meta;
                assign prev_vld  = in_valid;
            end else begin : g_rest
                assign prev_rem  = rem_reg[i-1];
                assign prev_den  = den_reg[i-1];
                assign prev_quo  = quo_reg[i-1];
                assign prev_meta = meta_reg[i-1];
                assign prev_vld  = vld_reg[i-1];
            end

            // one quotient bit per stage
            assign trial = {prev_rem, 1'b0};
            assign ge    = trial >= {1'b0, prev_den};
            assign diff  = trial - {1'b0, prev_den};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[i] <= 1'b0;
                end else if (adv) begin
                    vld_reg[i] <= prev_vld;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[i]  <= ge ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
                    den_reg[i]  <= prev_den;
                    quo_reg[i]  <= {prev_quo[FRAC_BITS-2:0], ge};
                    meta_reg[i] <= prev_meta;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[FRAC_BITS-1];
    assign out_meta  = meta_reg[FRAC_BITS-1];
    assign out_quo   = quo_reg[FRAC_BITS-1];

endmodule

// ===== rtl/trapezoid_envelope.sv =====
// Trapezoid envelope generator: top level with config port, segment decode and output.
// Pipeline: 32 modulo stages, decode, FRAC_BITS divider stages, output.
// Throughput: one word per cycle unless the output stalls; the modulo and divider pipelines take one bit per stage.
// The whole pipeline holds while a result waits at the output and m_ready is low.
// Reset (aresetn low, synchronous) clears all valid bits and the four length registers.
module trapezoid_envelope #(
    parameter int LEN_BITS  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tre_pkg::TIME_BITS-1:0] s_time_now,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [FRAC_BITS:0]            m_level,
    output logic                          m_hold_start,
    output logic                          m_period_zero
);
    localparam int PW = LEN_BITS + 2;

    logic [LEN_BITS-1:0] rise_reg, hold_reg, fall_reg, off_reg;
    logic [PW-1:0]       period;
    logic                adv;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_reg <= '0;
            hold_reg <= '0;
            fall_reg <= '0;
            off_reg  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                tre_pkg::REG_RISE: rise_reg <= pwdata[LEN_BITS-1:0];
                tre_pkg::REG_HOLD: hold_reg <= pwdata[LEN_BITS-1:0];
                tre_pkg::REG_FALL: fall_reg <= pwdata[LEN_BITS-1:0];
                tre_pkg::REG_OFF:  off_reg  <= pwdata[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            tre_pkg::REG_RISE: prdata[LEN_BITS-1:0] = rise_reg;
            tre_pkg::REG_HOLD: prdata[LEN_BITS-1:0] = hold_reg;
            tre_pkg::REG_FALL: prdata[LEN_BITS-1:0] = fall_reg;
            tre_pkg::REG_OFF:  prdata[LEN_BITS-1:0] = off_reg;
            default: ;
        endcase
    end
    assign pready = 1'b1;

    // segment boundaries
    logic [PW-1:0] rise_x, hold_end, fall_end;
    assign rise_x   = PW'(rise_reg);
    assign hold_end = rise_x + PW'(hold_reg);
    assign fall_end = hold_end + PW'(fall_reg);
    assign period   = fall_end + PW'(off_reg);

    // global stall: advance when the output slot is free or being taken
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    logic          mod_valid;
    logic [PW-1:0] phase;

    tre_mod #(.LEN_BITS(LEN_BITS)) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_time   (s_time_now),
        .period    (period),
        .out_valid (mod_valid),
        .out_phase (phase)
    );

    // decode stage: pick segment, numerator and divisor
    tre_pkg::tre_meta_t  dec_meta_next, dec_meta_reg;
    logic [LEN_BITS-1:0] num_next, num_reg, den_next, den_reg;
    logic [PW-1:0]       left_w;
    logic                dec_vld_reg;

    assign left_w = PW'(fall_reg) - (phase - hold_end);

    always_comb begin
        dec_meta_next = '0;
        num_next      = '0;
        den_next      = '0;
        if (period == '0) begin
            dec_meta_next.period_zero = 1'b1;
            dec_meta_next.is_zero     = 1'b1;
        end else if (phase < rise_x) begin
            num_next = phase[LEN_BITS-1:0];
            den_next = rise_reg;
        end else if (phase < hold_end) begin
            dec_meta_next.is_full    = 1'b1;
            dec_meta_next.hold_start = (phase == rise_x);
        end else if (phase < fall_end) begin
            // first fall tick is still full level
            if (phase == hold_end) begin
                dec_meta_next.is_full = 1'b1;
            end else begin
                num_next = left_w[LEN_BITS-1:0];
                den_next = fall_reg;
            end
        end else begin
            dec_meta_next.is_zero = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_vld_reg <= 1'b0;
        end else if (adv) begin
            dec_vld_reg <= mod_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dec_meta_reg <= dec_meta_next;
            num_reg      <= num_next;
            den_reg      <= den_next;
        end
    end

    logic                 div_valid;
    tre_pkg::tre_meta_t   div_meta;
    logic [FRAC_BITS-1:0] quo;

    tre_div #(.LEN_BITS(LEN_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (dec_vld_reg),
        .in_meta   (dec_meta_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .out_valid (div_valid),
        .out_meta  (div_meta),
        .out_quo   (quo)
    );

    // output word register
    logic [FRAC_BITS:0] level_next, level_reg;
    logic               hs_reg, pz_reg;

    always_comb begin
        if (div_meta.is_full) begin
            level_next = (FRAC_BITS+1)'(1) << FRAC_BITS;
        end else if (div_meta.is_zero) begin
            level_next = '0;
        end else begin
            level_next = {1'b0, quo};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            level_reg <= level_next;
            hs_reg    <= div_meta.hold_start;
            pz_reg    <= div_meta.period_zero;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_level       = level_reg;
    assign m_hold_start  = hs_reg;
    assign m_period_zero = pz_reg;

    // checks
    a_pz_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_period_zero |-> m_level == '0 && !m_hold_start)
        else $error("period zero word with nonzero level");

    a_hs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hold_start |-> m_level == ((FRAC_BITS+1)'(1) << FRAC_BITS))
        else $error("hold start word not at full level");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

endmodule
